// ----- rtl/core/cco_pkg.sv -----
// ----------------------------------------------------------------------------
// cco_pkg: shared types and constants of the chain code outward offset unit
// Queue entry layout, register indexes and the direction step tables.
// ----------------------------------------------------------------------------
package cco_pkg;

   // default width of the offset start coordinates
   localparam int COORD_BITS_DEF = 16;

   // configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 15;
   localparam int BASE_BITS      = 15;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_START_X      = 2'd0,
      CSR_START_Y      = 2'd1,
      CSR_CLOSING_CODE = 2'd2
   } csr_index_type;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // fixed offsets and directions
   localparam logic [2:0] DIR_UP      = 3'd2;
   localparam logic [2:0] START_EVEN  = 3'd2;
   localparam logic [2:0] START_ODD   = 3'd3;
   localparam logic [2:0] ADD_EVEN_HI = 3'd3;
   localparam logic [1:0] ADD_EVEN_LO = 2'd1;
   localparam logic [2:0] ADD_ODD_HI  = 3'd4;
   localparam logic [1:0] ADD_ODD_LO  = 2'd2;

   // one classified item waiting for the back end
   typedef struct packed {
      logic       pixel;    // single-pixel object, emits 7,5,3,1
      logic       error;    // unreachable turn
      logic [1:0] cnt_m1;   // number of results minus one
      logic [2:0] code;
      logic       border;
      logic [2:0] off_hi;   // offset of the first added code
      logic [1:0] off_lo;   // offset of the second added code
      logic [2:0] sd;       // start offset direction
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // x step of a Freeman direction
   function automatic logic signed [1:0] dir_dx(input logic [2:0] dir);
      logic signed [1:0] d;
      case (dir)
         3'd0, 3'd1, 3'd7: d = 2'sd1;
         3'd3, 3'd4, 3'd5: d = -2'sd1;
         default:          d = 2'sd0;
      endcase
      return d;
   endfunction

   // y step of a Freeman direction, y grows downward
   function automatic logic signed [1:0] dir_dy(input logic [2:0] dir);
      logic signed [1:0] d;
      case (dir)
         3'd1, 3'd2, 3'd3: d = -2'sd1;
         3'd5, 3'd6, 3'd7: d = 2'sd1;
         default:          d = 2'sd0;
      endcase
      return d;
   endfunction

endpackage

// ----- rtl/core/cco_if.sv -----
// ----------------------------------------------------------------------------
// cco_if: item channels of the chain code outward offset unit
// Request channel carries chain code steps, response channel offset codes.
// ----------------------------------------------------------------------------
interface cco_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [2:0] code;
   logic       border;
   logic       first;

   modport source (output valid, action, code, border, first, input ready);
   modport sink   (input valid, action, code, border, first, output ready);
endinterface

interface cco_rsp_if #(
   parameter int COORD_BITS = cco_pkg::COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic [2:0]                   out_code;
   logic                         out_border;
   logic                         last;
   logic                         error;
   logic signed [COORD_BITS-1:0] new_start_x;
   logic signed [COORD_BITS-1:0] new_start_y;

   modport source (output valid, out_code, out_border, last, error, new_start_x,
                   new_start_y, input ready);
   modport sink   (input valid, out_code, out_border, last, error, new_start_x,
                   new_start_y, output ready);
endinterface

// ----- rtl/core/cco_front.sv -----
// ----------------------------------------------------------------------------
// cco_front: accept and classify chain code items
// Works out the turn against the previous code and builds a queue entry.
// ----------------------------------------------------------------------------
module cco_front (
   input  logic                      clock,
   input  logic                      reset,
   cco_req_if.sink                   req_if,
   input  logic [2:0]                closing_code,
   input  cco_pkg::queue_status_type q_status,
   output cco_pkg::push_type         push
);
   import cco_pkg::*;

   logic [2:0] prev_ff, prev_in;
   logic       accept;
   logic [2:0] prev_sel;
   logic [2:0] turn;
   logic       drop;
   entry_type  entry;

   // take an item whenever the queue has room
   assign req_if.ready = !q_status.full;
   assign accept       = req_if.valid && req_if.ready;

   // turn against the previous code
   assign prev_sel = req_if.first ? closing_code : prev_ff;
   assign turn     = req_if.code - prev_sel;

   // classify
   always_comb begin
      entry        = '0;
      drop         = 1'b0;
      entry.code   = req_if.code;
      entry.border = req_if.border;
      entry.sd     = closing_code + (closing_code[0] ? START_ODD : START_EVEN);
      if (req_if.action) begin
         entry.pixel  = 1'b1;
         entry.cnt_m1 = 2'd3;
         entry.border = 1'b0;
         entry.sd     = DIR_UP;
      end else if (!req_if.code[0]) begin
         case (turn)
            3'd2, 3'd3: begin
               entry.error  = 1'b1;
               entry.border = 1'b0;
            end
            3'd4, 3'd5: begin
               entry.cnt_m1 = 2'd2;
               entry.off_hi = ADD_EVEN_HI;
               entry.off_lo = ADD_EVEN_LO;
            end
            3'd6, 3'd7: begin
               entry.cnt_m1 = 2'd1;
               entry.off_lo = ADD_EVEN_LO;
            end
            default: begin
               entry.cnt_m1 = 2'd0;
            end
         endcase
      end else begin
         case (turn)
            3'd3: begin
               entry.error  = 1'b1;
               entry.border = 1'b0;
            end
            3'd1, 3'd2: begin
               drop = 1'b1;
            end
            3'd4: begin
               entry.cnt_m1 = 2'd2;
               entry.off_hi = ADD_ODD_HI;
               entry.off_lo = ADD_ODD_LO;
            end
            3'd5, 3'd6: begin
               entry.cnt_m1 = 2'd1;
               entry.off_lo = ADD_ODD_LO;
            end
            default: begin
               entry.cnt_m1 = 2'd0;
            end
         endcase
      end
   end

   assign push.valid = accept && !drop;
   assign push.entry = entry;

   // previous code follows every chain code step
   always_comb begin
      prev_in = prev_ff;
      if (accept && !req_if.action) begin
         prev_in = req_if.code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else begin
         prev_ff <= prev_in;
      end
   end

endmodule

// ----- rtl/core/cco_queue.sv -----
// ----------------------------------------------------------------------------
// cco_queue: short queue between front and back
// Small circular buffer of classified entries with an occupancy count.
// ----------------------------------------------------------------------------
module cco_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  cco_pkg::push_type         push,
   input  logic                      pop,
   output cco_pkg::entry_type        head,
   output cco_pkg::queue_status_type status
);
   import cco_pkg::*;

   entry_type            mem [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   assign status.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = mem[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push.valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push.valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

// ----- rtl/core/cco_back.sv -----
// ----------------------------------------------------------------------------
// cco_back: expand queue entries into result items
// Emits one result a cycle from the queue head into the output register while the receiver takes them.
// ----------------------------------------------------------------------------
module cco_back #(
   parameter int COORD_BITS = cco_pkg::COORD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  cco_pkg::entry_type              head,
   input  cco_pkg::queue_status_type       q_status,
   output logic                            pop,
   input  logic [cco_pkg::BASE_BITS-1:0]   start_x,
   input  logic [cco_pkg::BASE_BITS-1:0]   start_y,
   cco_rsp_if.source                       rsp_if
);
   import cco_pkg::*;

   localparam int WIDE = 33;
   localparam logic signed [WIDE-1:0] COORD_HI =
      (WIDE'(1) <<< (COORD_BITS - 1)) - WIDE'(1);
   localparam logic signed [WIDE-1:0] COORD_LO = -COORD_HI - WIDE'(1);

   // base plus one step, saturated to the coordinate range
   function automatic logic [COORD_BITS-1:0] sat_coord(
      input logic [BASE_BITS-1:0] base,
      input logic signed [1:0]    d
   );
      logic signed [BASE_BITS+1:0] sum;
      logic signed [WIDE-1:0]      wide;
      logic signed [WIDE-1:0]      sat;
      sum  = $signed({2'b00, base}) + $signed({{BASE_BITS{d[1]}}, d});
      wide = $signed({{(WIDE-BASE_BITS-2){sum[BASE_BITS+1]}}, sum});
      if (wide > COORD_HI) begin
         sat = COORD_HI;
      end else if (wide < COORD_LO) begin
         sat = COORD_LO;
      end else begin
         sat = wide;
      end
      return sat[COORD_BITS-1:0];
   endfunction

   logic                  valid_ff, valid_in;
   logic [1:0]            done_ff, done_in;
   logic [2:0]            code_ff, code_in;
   logic                  border_ff, border_in;
   logic                  last_ff, last_in;
   logic                  error_ff, error_in;
   logic [COORD_BITS-1:0] nx_ff, nx_in;
   logic [COORD_BITS-1:0] ny_ff, ny_in;

   logic       load;
   logic       emit;
   logic       is_last;
   logic [1:0] pos;
   logic [2:0] offset;

   // output register takes a new result when empty or being drained
   assign load    = !valid_ff || rsp_if.ready;
   assign emit    = load && !q_status.empty;
   assign is_last = (done_ff == head.cnt_m1);
   assign pop     = emit && is_last;
   assign pos     = head.cnt_m1 - done_ff;

   // offset of the code at this position
   always_comb begin
      case (pos)
         2'd2:    offset = head.off_hi;
         2'd1:    offset = {1'b0, head.off_lo};
         default: offset = 3'd0;
      endcase
   end

   // next result
   always_comb begin
      code_in   = code_ff;
      border_in = border_ff;
      last_in   = last_ff;
      error_in  = error_ff;
      nx_in     = nx_ff;
      ny_in     = ny_ff;
      if (emit) begin
         if (head.pixel) begin
            code_in = {pos, 1'b1};
         end else if (head.error) begin
            code_in = 3'd0;
         end else begin
            code_in = head.code + offset;
         end
         border_in = head.border;
         last_in   = is_last;
         error_in  = head.error;
         nx_in     = sat_coord(start_x, dir_dx(head.sd));
         ny_in     = sat_coord(start_y, dir_dy(head.sd));
      end
   end

   // control
   always_comb begin
      done_in  = done_ff;
      valid_in = valid_ff;
      if (emit) begin
         done_in  = is_last ? 2'd0 : done_ff + 2'd1;
         valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         done_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff   <= code_in;
      border_ff <= border_in;
      last_ff   <= last_in;
      error_ff  <= error_in;
      nx_ff     <= nx_in;
      ny_ff     <= ny_in;
   end

   assign rsp_if.valid       = valid_ff;
   assign rsp_if.out_code    = code_ff;
   assign rsp_if.out_border  = border_ff;
   assign rsp_if.last        = last_ff;
   assign rsp_if.error       = error_ff;
   assign rsp_if.new_start_x = $signed(nx_ff);
   assign rsp_if.new_start_y = $signed(ny_ff);

endmodule

// ----- rtl/core/chain_code_outward_offset_unit.sv -----
// ----------------------------------------------------------------------------
// chain_code_outward_offset_unit: outward offset of a Freeman chain code
// Each request item is one 8-connected chain code step (or a single-pixel
// object); the unit answers with the codes of the contour grown outward by one
// pixel, zero to four response items per request, the final one flagged by
// last, plus the shifted start point. Results leave at one per cycle from a
// registered output while the receiver is ready; a four-entry queue between
// the classifying front end and the expanding back end lets requests keep
// arriving while earlier results drain. Write start_x, start_y and
// closing_code only while no results are pending.
// ----------------------------------------------------------------------------
module chain_code_outward_offset_unit #(
   parameter int COORD_BITS = cco_pkg::COORD_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   cco_req_if.sink                            req_if,
   cco_rsp_if.source                          rsp_if,
   input  logic                               csr_we,
   input  logic [cco_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [cco_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import cco_pkg::*;

   logic [BASE_BITS-1:0] start_x_ff, start_x_in;
   logic [BASE_BITS-1:0] start_y_ff, start_y_in;
   logic [2:0]           closing_code_ff, closing_code_in;

   push_type         push;
   logic             pop;
   entry_type        head;
   queue_status_type q_status;

   // configuration registers
   always_comb begin
      start_x_in      = start_x_ff;
      start_y_in      = start_y_ff;
      closing_code_in = closing_code_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_START_X:      start_x_in      = csr_wdata[BASE_BITS-1:0];
            CSR_START_Y:      start_y_in      = csr_wdata[BASE_BITS-1:0];
            CSR_CLOSING_CODE: closing_code_in = csr_wdata[2:0];
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff      <= '0;
         start_y_ff      <= '0;
         closing_code_ff <= '0;
      end else begin
         start_x_ff      <= start_x_in;
         start_y_ff      <= start_y_in;
         closing_code_ff <= closing_code_in;
      end
   end

   // front end: accept and classify
   cco_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_if),
      .closing_code (closing_code_ff),
      .q_status     (q_status),
      .push         (push)
   );

   // queue between front and back
   cco_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (q_status)
   );

   // back end: expand into result items
   cco_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .start_x  (start_x_ff),
      .start_y  (start_y_ff),
      .rsp_if   (rsp_if)
   );

`ifndef SYNTH
   // an error item is a lone result with a cleared code
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.error |->
         rsp_if.last && (rsp_if.out_code == 3'd0) && !rsp_if.out_border)
      else $error("error result with code, border or missing last");

   // results of one item follow each other without a gap
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.ready && !rsp_if.last |=> rsp_if.valid)
      else $error("gap inside the results of one item");

   // nothing is offered right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("result offered after reset");
`endif

endmodule

// ----- tb/tb_chain_code_outward_offset_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_chain_code_outward_offset_unit: self-checking bench of the offset unit
// Feeds chain code steps and single-pixel items through the request channel,
// predicts the grown contour codes and start point in a bench-side model, and
// checks each response item against the oldest prediction while both sides
// idle, stall and hold off at random across several register settings.
// ----------------------------------------------------------------------------
module tb_chain_code_outward_offset_unit;
   import cco_pkg::*;

   localparam int COORD_BITS    = 16;
   localparam int SETTLE_CYCLES = 20;
   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 200000;

   localparam logic ACT_STEP  = 1'b0;
   localparam logic ACT_PIXEL = 1'b1;

   typedef struct packed {
      logic       action;
      logic [2:0] code;
      logic       border;
      logic       first;
   } chain_step_type;

   typedef struct packed {
      logic [2:0]                   code;
      logic                         border;
      logic                         last;
      logic                         error;
      logic signed [COORD_BITS-1:0] nx;
      logic signed [COORD_BITS-1:0] ny;
   } offset_code_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   cco_req_if                            req_if ();
   cco_rsp_if #(.COORD_BITS(COORD_BITS)) rsp_if ();

   chain_step_type  pending_steps [$];
   offset_code_type expected_codes [$];

   // bench copy of the registers and the previous code
   logic [BASE_BITS-1:0] cfg_start_x;
   logic [BASE_BITS-1:0] cfg_start_y;
   logic [2:0]           cfg_closing;
   logic [2:0]           prev_code = 3'd0;

   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   logic rsp_hold       = 1'b0;
   int   error_count    = 0;
   int   result_count   = 0;
   int   cycle_count    = 0;

   chain_code_outward_offset_unit #(.COORD_BITS(COORD_BITS)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("chain_code_outward_offset_unit verification failed");
         $finish;
      end
   end

   // x and y step of a direction, y grows downward
   function automatic int step_x(input logic [2:0] dir);
      case (dir)
         3'd0, 3'd1, 3'd7: return 1;
         3'd3, 3'd4, 3'd5: return -1;
         default:          return 0;
      endcase
   endfunction

   function automatic int step_y(input logic [2:0] dir);
      case (dir)
         3'd1, 3'd2, 3'd3: return -1;
         3'd5, 3'd6, 3'd7: return 1;
         default:          return 0;
      endcase
   endfunction

   // base plus step, clamped to the signed coordinate range
   function automatic logic signed [COORD_BITS-1:0] shifted_coord(
      input logic [BASE_BITS-1:0] base, input int d);
      longint v;
      longint hi;
      hi = (longint'(1) << (COORD_BITS - 1)) - 1;
      v  = longint'(base) + d;
      if (v > hi) v = hi;
      if (v < -hi - 1) v = -hi - 1;
      return COORD_BITS'(v);
   endfunction

   // turns that a contour of this parity cannot make
   function automatic bit turn_is_error(input logic [2:0] code, input logic [2:0] turn);
      return code[0] ? (turn == 3'd3) : (turn == 3'd2 || turn == 3'd3);
   endfunction

   // expected offset codes of one accepted item
   task automatic predict_offset_codes(input chain_step_type s);
      logic [2:0]                   prior;
      logic [2:0]                   turn;
      logic [2:0]                   dir;
      logic [2:0]                   emit [$];
      logic signed [COORD_BITS-1:0] nx;
      logic signed [COORD_BITS-1:0] ny;
      offset_code_type              r;
      int                           k;
      if (s.action == ACT_PIXEL) begin
         nx = shifted_coord(cfg_start_x, step_x(DIR_UP));
         ny = shifted_coord(cfg_start_y, step_y(DIR_UP));
         for (k = 0; k < 4; k++) emit.insert(emit.size(), 3'd7 - 3'(2 * k));
         s.border = 1'b0;
      end else begin
         // start moves one pixel in the direction two codes past the closing code, three when it is odd
         dir   = cfg_closing + (cfg_closing[0] ? 3'd3 : 3'd2);
         nx    = shifted_coord(cfg_start_x, step_x(dir));
         ny    = shifted_coord(cfg_start_y, step_y(dir));
         prior = s.first ? cfg_closing : prev_code;
         turn  = s.code - prior;
         prev_code = s.code;
         if (turn_is_error(s.code, turn)) begin
            r = '{code: 3'd0, border: 1'b0, last: 1'b1, error: 1'b1, nx: nx, ny: ny};
            expected_codes.insert(expected_codes.size(), r);
            return;
         end
         if (!s.code[0]) begin
            if (turn == 3'd4 || turn == 3'd5) emit.insert(emit.size(), s.code + 3'd3);
            if (turn >= 3'd4) emit.insert(emit.size(), s.code + 3'd1);
            emit.insert(emit.size(), s.code);
         end else if (turn != 3'd1 && turn != 3'd2) begin
            if (turn == 3'd4) emit.insert(emit.size(), s.code + 3'd4);
            if (turn >= 3'd4 && turn <= 3'd6) emit.insert(emit.size(), s.code + 3'd2);
            emit.insert(emit.size(), s.code);
         end
      end
      for (k = 0; k < emit.size(); k++) begin
         r = '{code: emit[k], border: s.border, last: (k == emit.size() - 1),
               error: 1'b0, nx: nx, ny: ny};
         expected_codes.insert(expected_codes.size(), r);
      end
   endtask

   task automatic report_mismatch(input string field, input int got, input int want);
      error_count++;
      $display("[%0t] result %0d %s: got %0d, expected %0d", $time, result_count,
               field, got, want);
   endtask

   // request driver: predicts on acceptance, holds an offered item until taken
   always @(posedge clock) begin : drive_steps
      chain_step_type taken;
      if (reset) begin
         req_if.valid  <= 1'b0;
         req_if.action <= ACT_STEP;
         req_if.code   <= 3'd0;
         req_if.border <= 1'b0;
         req_if.first  <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            taken = '{req_if.action, req_if.code, req_if.border, req_if.first};
            predict_offset_codes(taken);
            void'(pending_steps.pop_front());
         end
         if (!(req_if.valid && !req_if.ready)) begin
            if (pending_steps.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_if.valid  <= 1'b1;
               req_if.action <= pending_steps[0].action;
               req_if.code   <= pending_steps[0].code;
               req_if.border <= pending_steps[0].border;
               req_if.first  <= pending_steps[0].first;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and receiver stalls
   always @(posedge clock) begin : watch_codes
      offset_code_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_codes.size() == 0) begin
               report_mismatch("item with nothing expected", rsp_if.out_code, 0);
            end else begin
               want = expected_codes.pop_front();
               if (rsp_if.out_code !== want.code)
                  report_mismatch("out_code", rsp_if.out_code, want.code);
               if (rsp_if.out_border !== want.border)
                  report_mismatch("out_border", rsp_if.out_border, want.border);
               if (rsp_if.last !== want.last)
                  report_mismatch("last", rsp_if.last, want.last);
               if (rsp_if.error !== want.error)
                  report_mismatch("error", rsp_if.error, want.error);
               if (rsp_if.new_start_x !== want.nx)
                  report_mismatch("new_start_x", rsp_if.new_start_x, want.nx);
               if (rsp_if.new_start_y !== want.ny)
                  report_mismatch("new_start_y", rsp_if.new_start_y, want.ny);
            end
            result_count++;
         end
         rsp_if.ready <= !rsp_hold && ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // register writes, only while the unit is idle
   task automatic configure(input logic [BASE_BITS-1:0] x, input logic [BASE_BITS-1:0] y,
                            input logic [2:0] closing);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_START_X;
      csr_wdata <= CSR_DATA_BITS'(x);
      cfg_start_x = x;
      @(posedge clock);
      csr_index <= CSR_START_Y;
      csr_wdata <= CSR_DATA_BITS'(y);
      cfg_start_y = y;
      @(posedge clock);
      csr_index <= CSR_CLOSING_CODE;
      csr_wdata <= CSR_DATA_BITS'(closing);
      cfg_closing = closing;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // wait until every item is taken and answered, then let the unit settle
   task automatic wait_drained();
      do @(posedge clock);
      while (!(pending_steps.size() == 0 && !req_if.valid && expected_codes.size() == 0));
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly well-formed chains, some single pixels and loose noise
   task automatic push_random_items(input int count);
      chain_step_type s;
      logic [2:0]     gen_prev;
      logic [2:0]     turn;
      int             chain_left;
      int             made;
      chain_left = 0;
      gen_prev   = cfg_closing;
      for (made = 0; made < count; made++) begin
         s.action = ACT_STEP;
         s.border = 1'($urandom_range(0, 1));
         s.first  = 1'b0;
         if ($urandom_range(0, 99) < 8) begin
            s.action = ACT_PIXEL;
            s.code   = 3'($urandom_range(0, 7));
            s.first  = 1'($urandom_range(0, 1));
         end else if ($urandom_range(0, 99) < 10) begin
            s.code  = 3'($urandom_range(0, 7));
            s.first = 1'($urandom_range(0, 1));
         end else begin
            if (chain_left == 0) begin
               s.first    = 1'b1;
               gen_prev   = cfg_closing;
               chain_left = $urandom_range(3, 12);
            end
            turn = 3'($urandom_range(0, 7));
            // mostly steer away from impossible turns, same parity kept
            if (turn_is_error(gen_prev + turn, turn) && $urandom_range(0, 99) < 85)
               turn = turn + 3'd4;
            s.code = gen_prev + turn;
            chain_left--;
         end
         if (s.action == ACT_STEP) gen_prev = s.code;
         pending_steps.insert(pending_steps.size(), s);
      end
   endtask

   // stimulus phases
   initial begin
      logic [2:0]     walk [16];
      chain_step_type s;
      int             i;
      walk        = '{3'd0, 3'd1, 3'd2, 3'd4, 3'd7, 3'd3, 3'd0, 3'd6,
                      3'd5, 3'd5, 3'd7, 3'd2, 3'd6, 3'd3, 3'd1, 3'd0};
      csr_we      = 1'b0;
      csr_index   = CSR_START_X;
      csr_wdata   = '0;
      cfg_start_x = '0;
      cfg_start_y = '0;
      cfg_closing = 3'd0;
      reset       = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed walk: every turn for both parities, a single pixel in the
      // middle with junk fields, then a first code in mid chain
      configure('0, '0, 3'd0);
      for (i = 0; i < 16; i++) begin
         s = '{action: ACT_STEP, code: walk[i], border: i[0], first: (i == 0)};
         pending_steps.insert(pending_steps.size(), s);
         if (i == 7) begin
            s = '{action: ACT_PIXEL, code: 3'd7, border: 1'b1, first: 1'b1};
            pending_steps.insert(pending_steps.size(), s);
         end
      end
      s = '{action: ACT_STEP, code: 3'd3, border: 1'b1, first: 1'b1};
      pending_steps.insert(pending_steps.size(), s);
      wait_drained();

      // start point near the top of the range, odd closing code, sparse sender
      configure(15'd32766, 15'd32766, 3'd7);
      send_idle_pct = 86;
      push_random_items(60);
      wait_drained();

      // slow receiver
      configure(15'($urandom_range(0, 32766)), 15'($urandom_range(0, 32766)), 3'd1);
      send_idle_pct  = 0;
      recv_stall_pct = 86;
      push_random_items(60);
      wait_drained();

      // light idling on both sides
      configure(15'($urandom_range(0, 32766)), 15'($urandom_range(0, 32766)),
                3'($urandom_range(0, 7)));
      send_idle_pct  = 15;
      recv_stall_pct = 15;
      push_random_items(60);
      wait_drained();

      // receiver holds off long enough to back up the queue and the input
      configure(15'($urandom_range(0, 32766)), '0, 3'd6);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
      push_random_items(40);
      wait_drained();

      // sender pauses until everything has come back, then resumes
      configure(15'd32766, 15'd1, 3'd5);
      push_random_items(20);
      wait_drained();
      push_random_items(20);
      wait_drained();

      // full rate, fresh settings
      configure(15'($urandom_range(0, 32766)), 15'($urandom_range(0, 32766)),
                3'($urandom_range(0, 7)));
      push_random_items(80);
      wait_drained();

      if (error_count == 0) begin
         $display("chain_code_outward_offset_unit verification clean");
      end else begin
         $display("chain_code_outward_offset_unit verification failed");
      end
      $finish;
   end

endmodule
